// ===== sv/assert_macros.svh =====
// Assertion macros shared by the link quality monitor RTL.
// Expects clk and rst in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RLQM_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define RLQM_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RLQM_ASSERT_IMPL(name, pre, post, msg)
`define RLQM_ASSERT_NEXT(name, pre, post, msg)
`endif

`endif

// ===== sv/rlqm_pkg.sv =====
// Shared types and constants for the radio link quality monitor.
// No dependencies.
package rlqm_pkg;

  localparam int WINDOW_LEN = 50;
  localparam int SCORE_W    = 26;

  localparam logic signed [SCORE_W-1:0] LOSS_WEIGHT = SCORE_W'(127);
  localparam logic signed [SCORE_W-1:0] FADE_WEIGHT = SCORE_W'(50);
  localparam logic signed [SCORE_W-1:0] SCORE_CAP_S = SCORE_W'(230);

  localparam logic [7:0]  SCORE_CAP   = 8'd230;
  localparam logic [7:0]  HOLD_SCORE  = 8'd255;
  localparam logic [7:0]  QUALITY_MAX = 8'd255;
  localparam logic [7:0]  GAP_RESET   = 8'd10;
  localparam logic [15:0] MS_MAX      = 16'hFFFF;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic  operation;
    byte_t data_byte;
  } rlqm_item_t;

  typedef struct packed {
    byte_t link_quality;
    logic  packet_done;
    logic  hold_active;
    byte_t latest_loss;
  } rlqm_result_t;

endpackage

// ===== sv/rlqm_cell.sv =====
// One window cell: holds a loss score and passes a running maximum on.
// Depends on rlqm_pkg.
module rlqm_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,
  input  rlqm_pkg::byte_t entry_in,
  input  rlqm_pkg::byte_t max_in,
  output rlqm_pkg::byte_t entry_out,
  output rlqm_pkg::byte_t max_out
);
  import rlqm_pkg::*;

  byte_t entry;
  byte_t max_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry   <= '0;
      max_val <= '0;
    end else begin
      if (shift_en) begin
        entry <= entry_in;
      end
      max_val <= (entry > max_in) ? entry : max_in;
    end
  end

  assign entry_out = entry;
  assign max_out   = max_val;

endmodule

// ===== sv/rlqm_window.sv =====
// Loss window: a shift chain of cells with a systolic running maximum.
// Depends on rlqm_pkg and rlqm_cell.
module rlqm_window (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  rlqm_pkg::byte_t shift_data,
  output rlqm_pkg::byte_t worst
);
  import rlqm_pkg::*;

  byte_t entry_chain [WINDOW_LEN+1];
  byte_t max_chain   [WINDOW_LEN+1];

  assign entry_chain[0] = shift_data;
  assign max_chain[0]   = '0;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    rlqm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (shift_en),
      .entry_in  (entry_chain[i]),
      .max_in    (max_chain[i]),
      .entry_out (entry_chain[i+1]),
      .max_out   (max_chain[i+1])
    );
  end

  assign worst = max_chain[WINDOW_LEN];

endmodule

// ===== sv/radio_link_quality_monitor.sv =====
// Radio link quality monitor top level: packet parsing, loss score, hold tracking.
// Items that do not end a packet go from idle to emit; the byte that ends a packet
// passes score, clamp, sweep and emit (the window maximum ripples one cell a cycle).
// New items are taken only in idle, after the last result has been emitted.
// Synchronous reset clears all state and the window; gap threshold returns to 10 ms.
// Depends on rlqm_pkg, rlqm_window and assert_macros.svh.
`include "assert_macros.svh"

module radio_link_quality_monitor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  rlqm_pkg::rlqm_item_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output rlqm_pkg::rlqm_result_t result,
  input  logic                   cfg_we,
  input  rlqm_pkg::byte_t        cfg_wdata
);
  import rlqm_pkg::*;

  localparam int SWEEP_W = $clog2(WINDOW_LEN + 1);
  localparam logic [SWEEP_W-1:0] SWEEP_LAST = SWEEP_W'(WINDOW_LEN - 1);

  localparam logic [3:0] POS_HOLD    = 4'd1;
  localparam logic [3:0] POS_LOSS_HI = 4'd2;
  localparam logic [3:0] POS_LOSS_LO = 4'd3;
  localparam logic [3:0] POS_MAIN_HI = 4'd4;
  localparam logic [3:0] POS_MAIN_LO = 4'd5;
  localparam logic [3:0] POS_SAT_HI  = 4'd6;
  localparam logic [3:0] POS_SAT_LO  = 4'd7;

  typedef enum logic [2:0] {S_IDLE, S_SCORE, S_CLAMP, S_SWEEP, S_EMIT} state_t;

  state_t               state;
  logic [SWEEP_W-1:0]   sweep_cnt;
  byte_t                gap_threshold;
  logic                 awaiting_packet;
  logic [3:0]           byte_position;
  logic [15:0]          ms_since_byte;
  byte_t                hold_count_new;
  logic [15:0]          frame_loss_new;
  logic [15:0]          main_fades_new;
  logic [15:0]          sat_fades_new;
  byte_t                hold_count_prev;
  logic [15:0]          frame_loss_prev;
  logic [15:0]          main_fades_prev;
  logic [15:0]          sat_fades_prev;
  logic                 in_hold;
  byte_t                last_score;
  logic                 done;
  logic                 fresh_hold;
  logic signed [SCORE_W-1:0] p_loss;
  logic signed [SCORE_W-1:0] p_main;
  logic signed [SCORE_W-1:0] p_sat;

  logic                 accept;
  logic [15:0]          loss_delta;
  logic signed [16:0]   main_delta;
  logic signed [16:0]   sat_delta;
  logic signed [SCORE_W-1:0] score_sum;
  byte_t                score;
  logic                 win_shift;
  byte_t                worst;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign win_shift  = (state == S_CLAMP);

  always_comb begin
    loss_delta = (frame_loss_new > frame_loss_prev) ? frame_loss_new - frame_loss_prev : '0;
    main_delta = signed'({1'b0, main_fades_new}) - signed'({1'b0, main_fades_prev});
    sat_delta  = signed'({1'b0, sat_fades_new}) - signed'({1'b0, sat_fades_prev});
    score_sum  = p_loss + p_main + p_sat;
    if (fresh_hold) begin
      score = HOLD_SCORE;
    end else if (score_sum > SCORE_CAP_S) begin
      score = SCORE_CAP;
    end else if (score_sum < 0) begin
      score = '0;
    end else begin
      score = score_sum[7:0];
    end
  end

  rlqm_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (win_shift),
    .shift_data (score),
    .worst      (worst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      sweep_cnt       <= '0;
      gap_threshold   <= GAP_RESET;
      awaiting_packet <= 1'b1;
      byte_position   <= '0;
      ms_since_byte   <= '0;
      hold_count_new  <= '0;
      frame_loss_new  <= '0;
      main_fades_new  <= '0;
      sat_fades_new   <= '0;
      hold_count_prev <= '0;
      frame_loss_prev <= '0;
      main_fades_prev <= '0;
      sat_fades_prev  <= '0;
      in_hold         <= 1'b0;
      last_score      <= '0;
      done            <= 1'b0;
      fresh_hold      <= 1'b0;
      p_loss          <= '0;
      p_main          <= '0;
      p_sat           <= '0;
      result_valid    <= 1'b0;
      result          <= '0;
    end else begin
      if (cfg_we) begin
        gap_threshold <= cfg_wdata;
      end
      if (result_valid && result_ready && state != S_EMIT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (item.operation == OP_BYTE && !awaiting_packet &&
                byte_position == POS_SAT_LO) begin
              done  <= 1'b1;
              state <= S_SCORE;
            end else begin
              done  <= 1'b0;
              state <= S_EMIT;
            end
            if (item.operation == OP_TICK) begin
              if (ms_since_byte != MS_MAX) begin
                ms_since_byte <= ms_since_byte + 16'd1;
              end
            end else begin
              ms_since_byte <= '0;
              if (awaiting_packet) begin
                if (ms_since_byte > {8'd0, gap_threshold}) begin
                  awaiting_packet <= 1'b0;
                  byte_position   <= POS_HOLD;
                end
              end else begin
                byte_position <= byte_position + 4'd1;
                case (byte_position)
                  POS_HOLD:    hold_count_new       <= item.data_byte;
                  POS_LOSS_HI: frame_loss_new       <= {item.data_byte, 8'd0};
                  POS_LOSS_LO: frame_loss_new[7:0]  <= item.data_byte;
                  POS_MAIN_HI: main_fades_new       <= {item.data_byte, 8'd0};
                  POS_MAIN_LO: main_fades_new[7:0]  <= item.data_byte;
                  POS_SAT_HI:  sat_fades_new        <= {item.data_byte, 8'd0};
                  POS_SAT_LO: begin
                    sat_fades_new[7:0] <= item.data_byte;
                    awaiting_packet    <= 1'b1;
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        S_SCORE: begin
          fresh_hold <= (hold_count_new != hold_count_prev);
          p_loss     <= signed'(SCORE_W'(loss_delta)) * LOSS_WEIGHT;
          p_main     <= SCORE_W'(main_delta) * FADE_WEIGHT;
          p_sat      <= SCORE_W'(sat_delta) * FADE_WEIGHT;
          state      <= S_CLAMP;
        end
        S_CLAMP: begin
          if (fresh_hold) begin
            in_hold <= 1'b1;
          end else if (score != '0 && score != HOLD_SCORE) begin
            in_hold <= 1'b0;
          end
          last_score      <= score;
          hold_count_prev <= hold_count_new;
          frame_loss_prev <= frame_loss_new;
          main_fades_prev <= main_fades_new;
          sat_fades_prev  <= sat_fades_new;
          sweep_cnt       <= '0;
          state           <= S_SWEEP;
        end
        S_SWEEP: begin
          if (sweep_cnt == SWEEP_LAST) begin
            state <= S_EMIT;
          end else begin
            sweep_cnt <= sweep_cnt + SWEEP_W'(1);
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result_valid        <= 1'b1;
            result.link_quality <= in_hold ? '0 : QUALITY_MAX - worst;
            result.packet_done  <= done;
            result.hold_active  <= in_hold;
            result.latest_loss  <= last_score;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RLQM_ASSERT_IMPL(a_hold_zero_quality, result_valid && result.hold_active, result.link_quality == '0, "quality nonzero during hold")
  `RLQM_ASSERT_IMPL(a_hold_score_sets_hold, last_score > SCORE_CAP, in_hold, "hold score stored without hold")
  `RLQM_ASSERT_IMPL(a_score_after_packet_end, state == S_SCORE, awaiting_packet && done, "score pass without packet end")
  `RLQM_ASSERT_NEXT(a_tick_saturates, accept && item.operation == OP_TICK && ms_since_byte == MS_MAX, ms_since_byte == MS_MAX, "tick counter wrapped")

endmodule

// ===== dv/rlqm_quality_checker.sv =====
// Checker for the radio link quality monitor: watches the item, result and config ports,
// predicts each result beat from its own copy of the monitor state and compares field by field.
// Depends on rlqm_pkg.
module rlqm_quality_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  logic                   item_ready,
  input  rlqm_pkg::rlqm_item_t   item,
  input  logic                   result_valid,
  input  logic                   result_ready,
  input  rlqm_pkg::rlqm_result_t result,
  input  logic                   cfg_we,
  input  rlqm_pkg::byte_t        cfg_wdata,
  output int                     errors,
  output int                     pending
);
  import rlqm_pkg::*;

  localparam int LOSS_W    = 127;
  localparam int FADE_W    = 50;
  localparam int LOSS_CAP  = 230;
  localparam int HOLD_LOSS = 255;
  localparam logic [3:0] LAST_POS = 4'd7;
  localparam int PRINT_MAX = 40;

  byte_t       gap_ms;
  logic        awaiting;
  logic [3:0]  pos;
  logic [15:0] quiet_ms;
  byte_t       hold_cnt, hold_cnt_prev;
  logic [15:0] fl_count, fl_count_prev;
  logic [15:0] fades_main, fades_main_prev;
  logic [15:0] fades_sat, fades_sat_prev;
  logic        holding;
  byte_t       loss_ring [WINDOW_LEN];
  int          ring_wr;
  byte_t       last_loss;
  int          fail_count = 0;

  rlqm_result_t quality_due[$];
  rlqm_result_t want;

  assign errors = fail_count;

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < PRINT_MAX)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  function automatic rlqm_result_t predict_quality(input rlqm_item_t beat);
    rlqm_result_t r;
    logic closing;
    logic fresh;
    int rise_fl;
    int diff_fades;
    int score;
    int worst;
    byte_t b;
    b = beat.data_byte;
    closing = 1'b0;
    if (beat.operation == OP_TICK) begin
      if (quiet_ms != MS_MAX) quiet_ms++;
    end else begin
      if (awaiting) begin
        if (quiet_ms > gap_ms) begin
          awaiting = 1'b0;
          pos = 4'd1;
        end
      end else begin
        case (pos)
          4'd1: hold_cnt = b;
          4'd2: fl_count = {b, 8'h00};
          4'd3: fl_count[7:0] = b;
          4'd4: fades_main = {b, 8'h00};
          4'd5: fades_main[7:0] = b;
          4'd6: fades_sat = {b, 8'h00};
          4'd7: fades_sat[7:0] = b;
          default: ;
        endcase
        if (pos == LAST_POS) begin
          closing = 1'b1;
          if (hold_cnt != hold_cnt_prev) begin
            fresh = 1'b1;
            score = HOLD_LOSS;
          end else begin
            fresh = 1'b0;
            rise_fl = 0;
            if (fl_count > fl_count_prev)
              rise_fl = {16'h0, fl_count} - {16'h0, fl_count_prev};
            diff_fades = ({16'h0, fades_main} - {16'h0, fades_main_prev})
                       + ({16'h0, fades_sat} - {16'h0, fades_sat_prev});
            score = LOSS_W * rise_fl + FADE_W * diff_fades;
            if (score > LOSS_CAP) score = LOSS_CAP;
            if (score < 0) score = 0;
          end
          if (holding && score > 0 && score < HOLD_LOSS) holding = 1'b0;
          if (fresh) holding = 1'b1;
          loss_ring[ring_wr] = byte_t'(score);
          ring_wr = (ring_wr == WINDOW_LEN - 1) ? 0 : ring_wr + 1;
          last_loss = byte_t'(score);
          hold_cnt_prev = hold_cnt;
          fl_count_prev = fl_count;
          fades_main_prev = fades_main;
          fades_sat_prev = fades_sat;
          awaiting = 1'b1;
        end
        pos = pos + 4'd1;
      end
      quiet_ms = '0;
    end
    worst = 0;
    for (int i = 0; i < WINDOW_LEN; i++)
      if (loss_ring[i] > worst) worst = loss_ring[i];
    r.link_quality = holding ? 8'd0 : QUALITY_MAX - byte_t'(worst);
    r.packet_done  = closing;
    r.hold_active  = holding;
    r.latest_loss  = last_loss;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gap_ms = GAP_RESET;
      awaiting = 1'b1;
      pos = '0;
      quiet_ms = '0;
      hold_cnt = '0;
      hold_cnt_prev = '0;
      fl_count = '0;
      fl_count_prev = '0;
      fades_main = '0;
      fades_main_prev = '0;
      fades_sat = '0;
      fades_sat_prev = '0;
      holding = 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) loss_ring[i] = '0;
      ring_wr = 0;
      last_loss = '0;
      quality_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (quality_due.size() == 0) begin
          report_mismatch("result beat with nothing expected", result, 0);
        end else begin
          want = quality_due.pop_front();
          if (result.link_quality != want.link_quality)
            report_mismatch("link_quality", result.link_quality, want.link_quality);
          if (result.packet_done != want.packet_done)
            report_mismatch("packet_done", result.packet_done, want.packet_done);
          if (result.hold_active != want.hold_active)
            report_mismatch("hold_active", result.hold_active, want.hold_active);
          if (result.latest_loss != want.latest_loss)
            report_mismatch("latest_loss", result.latest_loss, want.latest_loss);
        end
      end
      if (cfg_we) gap_ms = cfg_wdata;
      if (item_valid && item_ready) quality_due.push_back(predict_quality(item));
    end
    pending = quality_due.size();
  end

endmodule

// ===== dv/radio_link_quality_monitor_tb.sv =====
// Top of the radio link quality monitor testbench: clock, reset, telemetry stimulus,
// receiver stalls, gap threshold changes, watchdog and verdict.
// Depends on rlqm_pkg, radio_link_quality_monitor and rlqm_quality_checker.
module radio_link_quality_monitor_tb;
  import rlqm_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_BEATS    = 160;
  localparam int LONG_SILENCE   = 260;

  typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         item_valid = 1'b0;
  logic         item_ready;
  rlqm_item_t   item = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  rlqm_result_t result;
  logic         cfg_we = 1'b0;
  byte_t        cfg_wdata = '0;
  int           errors;
  int           pending;

  rx_mode_t    rx_mode = RX_FREE;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  int          rx_count = 0;
  int          burst_left = 0;
  logic        steady = 1'b0;
  int          sent_beats = 0;
  int          idle_cycles = 0;
  byte_t       cur_gap = GAP_RESET;
  byte_t       sent_hold = '0;
  logic [15:0] sent_fl = '0;
  logic [15:0] sent_mf = '0;
  logic [15:0] sent_sf = '0;

  radio_link_quality_monitor DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  rlqm_quality_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .errors       (errors),
    .pending      (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLDOFF_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      result_ready = 1'b0;
      hold_left--;
    end else begin
      rx_count++;
      case (rx_mode)
        RX_FREE:   result_ready = 1'b1;
        RX_RANDOM: result_ready = $urandom_range(0, 99) < 65;
        default:   result_ready = (rx_count % 11) >= 3;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("radio_link_quality_monitor test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_beat(input logic op, input byte_t b);
    if (!steady && burst_left == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 20);
    end
    item_valid = 1'b1;
    item.operation = op;
    item.data_byte = b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    sent_beats++;
  endtask

  task automatic send_packet(input int quiet, input byte_t hdr, input byte_t hold,
                             input logic [15:0] fl, input logic [15:0] mf,
                             input logic [15:0] sf, input int n_body);
    byte_t body [7];
    body = '{hold, fl[15:8], fl[7:0], mf[15:8], mf[7:0], sf[15:8], sf[7:0]};
    repeat (quiet) send_beat(OP_TICK, byte_t'($urandom));
    send_beat(OP_BYTE, hdr);
    for (int i = 0; i < n_body; i++) send_beat(OP_BYTE, body[i]);
    if (n_body == 7) begin
      sent_hold = hold;
      sent_fl = fl;
      sent_mf = mf;
      sent_sf = sf;
    end
  endtask

  task automatic settle_and_set_gap(input byte_t gap);
    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = gap;
    @(negedge clk);
    cfg_we = 1'b0;
    cur_gap = gap;
  endtask

  function automatic logic [15:0] next_count(input logic [15:0] prev);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return prev;
    if (r < 60) return prev + 16'($urandom_range(1, 2));
    if (r < 75) return prev - 16'($urandom_range(1, 2));
    if (r < 85) return 16'($urandom);
    if (r < 92) return 16'hFFFF;
    return 16'h0000;
  endfunction

  initial begin
    int start;
    int r;
    int quiet;
    int n_body;
    byte_t g;
    byte_t hold;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // byte with no quiet gap before it: ignored
    send_beat(OP_BYTE, 8'h80);
    // first packet on the reset threshold, new hold count
    send_packet(11, 8'hA5, 8'h80, 16'hFF80, 16'h0080, 16'hFFFF, 7);
    settle_and_set_gap(8'd0);
    // fade counters drop: negative loss clamps to zero, hold stays
    send_packet(1, 8'h5A, 8'h80, 16'hFF80, 16'h0000, 16'hFFFF, 7);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       g = 8'd0;
        1:       g = 8'd255;
        default: g = byte_t'($urandom_range(1, 12));
      endcase
      settle_and_set_gap(g);
      rx_mode = rx_mode_t'(ph % 3);
      if (ph == 2) hold_request = 1'b1;
      start = sent_beats;
      while (sent_beats - start < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 75 || r >= 90) begin
          quiet = $urandom_range(0, 99);
          if (quiet < 80) quiet = cur_gap + 1 + $urandom_range(0, 2);
          else if (quiet < 90) quiet = cur_gap;
          else quiet = $urandom_range(0, cur_gap + 3);
          hold = ($urandom_range(0, 99) < 12) ? byte_t'($urandom) : sent_hold;
          n_body = (r >= 90) ? $urandom_range(1, 6) : 7;
          send_packet(quiet, byte_t'($urandom), hold, next_count(sent_fl),
                      next_count(sent_mf), next_count(sent_sf), n_body);
        end else begin
          repeat ($urandom_range(1, 8))
            send_beat(logic'($urandom_range(0, 1)), byte_t'($urandom));
        end
      end
    end

    // long silence above the largest threshold: the header is taken
    settle_and_set_gap(8'd255);
    rx_mode = RX_FREE;
    steady = 1'b1;
    send_packet(LONG_SILENCE, 8'hC3, sent_hold, sent_fl, sent_mf + 16'd1, sent_sf, 7);

    item_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0)
      $display("radio_link_quality_monitor test passed");
    else
      $display("radio_link_quality_monitor test failed");
    $finish;
  end

endmodule
